// ----- hdl/crs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types and fixed-point constants for the Catmull-Rom curve sampler.
// ----------------------------------------------------------------------------
package crs_pkg;

  // Coordinates are signed Q16.16.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned FRAC_W  = 16;

  // Basis weights are signed Q1.16; the largest magnitude is exactly one.
  localparam int unsigned WEIGHT_W = 18;

  // One weight times one coordinate, and the sum of four such products.
  localparam int unsigned PROD_W = WEIGHT_W + COORD_W;
  localparam int unsigned SUM_W  = PROD_W + 2;

  // Depth of the segment job queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One segment job: four control points in curve order. A single job emits
  // one sample at t = 0, which is the second point passed through unchanged.
  typedef struct packed {
    logic [3:0][COORD_W-1:0] px;
    logic [3:0][COORD_W-1:0] py;
    logic                    single;
  } job_t;

endpackage
`default_nettype wire

// ----- hdl/catmull_rom_curve_sampler_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// catmull_rom_curve_sampler_top
// Uniform Catmull-Rom curve sampler over a stream of Q16.16 control points.
// ----------------------------------------------------------------------------
// Each accepted control point closes at most one segment, which comes out as
// SAMPLES_PER_SEGMENT samples at one sample per cycle while the output is not
// stalled; a point marked last adds the final segment and the end point
// itself, so it yields up to 2*SAMPLES_PER_SEGMENT+1 transactions. Sustained
// throughput is set by the single multiply-and-sum pipeline that produces the
// samples. The front stalls its input while it pushes a point's jobs into a
// two-entry queue, also while that queue is full, and a job at the head of
// that queue passes through the weight, product and sum registers before its
// sample reaches the output register. Results are rounded to nearest and
// saturated.
// ----------------------------------------------------------------------------
module catmull_rom_curve_sampler_top #(
  parameter int unsigned SAMPLES_PER_SEGMENT = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [crs_pkg::COORD_W-1:0] point_x_i,
  input  wire logic [crs_pkg::COORD_W-1:0] point_y_i,
  input  wire logic                        last_point_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [crs_pkg::COORD_W-1:0]      curve_x_o,
  output logic [crs_pkg::COORD_W-1:0]      curve_y_o,
  output logic                             final_sample_o
);

  logic          fj_valid, fj_ready;
  crs_pkg::job_t fj_data;
  logic          bj_valid, bj_pop;
  crs_pkg::job_t bj_data;

  // Point window and job classification.
  crs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .last_point_i (last_point_i),
    .job_valid_o  (fj_valid),
    .job_ready_i  (fj_ready),
    .job_o        (fj_data)
  );

  // Segment job queue.
  crs_queue #(
    .DEPTH (crs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fj_valid),
    .wr_ready_o (fj_ready),
    .wr_data_i  (fj_data),
    .rd_valid_o (bj_valid),
    .rd_ready_i (bj_pop),
    .rd_data_o  (bj_data)
  );

  // Sample generation.
  crs_back #(
    .SAMPLES_PER_SEGMENT (SAMPLES_PER_SEGMENT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (bj_valid),
    .job_pop_o      (bj_pop),
    .job_i          (bj_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .curve_x_o      (curve_x_o),
    .curve_y_o      (curve_y_o),
    .final_sample_o (final_sample_o)
  );

endmodule
`default_nettype wire

// ----- hdl/crs_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crs_queue
// Small first-in first-out queue of segment jobs between front and back.
// ----------------------------------------------------------------------------
module crs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire crs_pkg::job_t wr_data_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output crs_pkg::job_t      rd_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  crs_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign wr_ready_o = (count_q != CNT_W'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/crs_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crs_front
// Accepts control points, keeps the three-point window and turns each point
// into zero to three segment jobs, pushed one per cycle while the queue has room.
// ----------------------------------------------------------------------------
module crs_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [crs_pkg::COORD_W-1:0]    point_x_i,
  input  wire logic [crs_pkg::COORD_W-1:0]    point_y_i,
  input  wire logic                           last_point_i,
  output logic                                job_valid_o,
  input  wire logic                           job_ready_i,
  output crs_pkg::job_t                       job_o
);

  // Pending job kinds, pushed in this order.
  localparam int unsigned JOB_MAIN = 0;  // segment closed by the new point
  localparam int unsigned JOB_TAIL = 1;  // final segment of the run
  localparam int unsigned JOB_FIN  = 2;  // closing end point
  localparam int unsigned JOB_N    = 3;

  localparam logic [1:0] SEEN_FULL = 2'd3;

  logic [JOB_N-1:0]            mask_q, mask_d, new_mask, mask_next;
  logic [1:0]                  seen_q, seen_d;
  logic [crs_pkg::COORD_W-1:0] win_x_q [3];
  logic [crs_pkg::COORD_W-1:0] win_y_q [3];
  logic [crs_pkg::COORD_W-1:0] hold_x_q, hold_y_q;
  logic                        hold_last_q;
  logic                        accept, push, upd;
  logic [crs_pkg::COORD_W-1:0] upd_x, upd_y;
  logic                        upd_last;

  assign in_stall_o  = (mask_q != '0);
  assign accept      = in_valid_i && !in_stall_o;
  assign job_valid_o = (mask_q != '0);
  assign push        = job_valid_o && job_ready_i;

  // Classify the incoming point by how many points the run already holds.
  always_comb begin
    new_mask = '0;
    if (seen_q != '0) begin
      new_mask[JOB_MAIN] = seen_q[1];
      new_mask[JOB_TAIL] = last_point_i;
      new_mask[JOB_FIN]  = last_point_i;
    end
  end

  // Build the job at the head of the pending set.
  always_comb begin
    job_o = '0;
    priority if (mask_q[JOB_MAIN]) begin
      job_o.px[0] = (seen_q == SEEN_FULL) ? win_x_q[0] : win_x_q[1];
      job_o.py[0] = (seen_q == SEEN_FULL) ? win_y_q[0] : win_y_q[1];
      job_o.px[1] = win_x_q[1];
      job_o.py[1] = win_y_q[1];
      job_o.px[2] = win_x_q[2];
      job_o.py[2] = win_y_q[2];
      job_o.px[3] = hold_x_q;
      job_o.py[3] = hold_y_q;
    end else if (mask_q[JOB_TAIL]) begin
      job_o.px[0] = (seen_q == 2'd1) ? win_x_q[2] : win_x_q[1];
      job_o.py[0] = (seen_q == 2'd1) ? win_y_q[2] : win_y_q[1];
      job_o.px[1] = win_x_q[2];
      job_o.py[1] = win_y_q[2];
      job_o.px[2] = hold_x_q;
      job_o.py[2] = hold_y_q;
      job_o.px[3] = hold_x_q;
      job_o.py[3] = hold_y_q;
    end else begin
      job_o.px     = {4{hold_x_q}};
      job_o.py     = {4{hold_y_q}};
      job_o.single = 1'b1;
    end
  end

  // Pending set and window update once an item has no jobs left.
  always_comb begin
    mask_next = mask_q & (mask_q - 1'b1);
    mask_d    = mask_q;
    if (accept) begin
      mask_d = new_mask;
    end else if (push) begin
      mask_d = mask_next;
    end
    upd      = (accept && (new_mask == '0)) || (push && (mask_next == '0));
    upd_x    = accept ? point_x_i : hold_x_q;
    upd_y    = accept ? point_y_i : hold_y_q;
    upd_last = accept ? last_point_i : hold_last_q;
    seen_d   = seen_q;
    if (upd) begin
      if (upd_last) begin
        seen_d = '0;
      end else begin
        seen_d = (seen_q == SEEN_FULL) ? SEEN_FULL : seen_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      seen_q <= '0;
    end else begin
      mask_q <= mask_d;
      seen_q <= seen_d;
    end
  end

  // Point window and held transaction; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_x_q    <= point_x_i;
      hold_y_q    <= point_y_i;
      hold_last_q <= last_point_i;
    end
    if (upd && !upd_last) begin
      win_x_q[0] <= win_x_q[1];
      win_x_q[1] <= win_x_q[2];
      win_x_q[2] <= upd_x;
      win_y_q[0] <= win_y_q[1];
      win_y_q[1] <= win_y_q[2];
      win_y_q[2] <= upd_y;
    end
  end

  // A pending segment always has at least one held point to start from.
  a_pending_has_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q != '0) |-> (seen_q != '0))
    else $error("front: jobs pending with an empty window");

  // The run count does not move while jobs of an item are pending.
  a_seen_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q != '0 && mask_next != '0 && push) |=> $stable(seen_q))
    else $error("front: window count changed in the middle of an item");

endmodule
`default_nettype wire

// ----- hdl/crs_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crs_back
// Steps through each segment job's samples, one per cycle while the output
// is free, via a weight, multiply, sum and round pipeline to the output register.
// ----------------------------------------------------------------------------
module crs_back #(
  parameter int unsigned SAMPLES_PER_SEGMENT = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        job_valid_i,
  output logic                             job_pop_o,
  input  wire crs_pkg::job_t               job_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [crs_pkg::COORD_W-1:0]      curve_x_o,
  output logic [crs_pkg::COORD_W-1:0]      curve_y_o,
  output logic                             final_sample_o
);

  localparam int unsigned CNT_W    = (SAMPLES_PER_SEGMENT > 1) ?
                                     $clog2(SAMPLES_PER_SEGMENT) : 1;
  localparam int unsigned WEIGHT_W = crs_pkg::WEIGHT_W;
  localparam int unsigned COORD_W  = crs_pkg::COORD_W;
  localparam int unsigned PROD_W   = crs_pkg::PROD_W;
  localparam int unsigned SUM_W    = crs_pkg::SUM_W;
  localparam int unsigned FRAC_W   = crs_pkg::FRAC_W;
  localparam longint      ONE_Q    = 64'sd65536;

  // Basis weight table, one row per sample position, worked out at build
  // time with round to nearest, ties toward plus infinity.
  logic [3:0][WEIGHT_W-1:0] w_tab [SAMPLES_PER_SEGMENT];

  for (genvar gs = 0; gs < SAMPLES_PER_SEGMENT; gs++) begin : g_wt
    localparam longint LN   = longint'(SAMPLES_PER_SEGMENT);
    localparam longint LS   = longint'(gs);
    localparam longint DEN  = 2 * LN * LN * LN;
    localparam longint DEN2 = 2 * DEN;
    localparam longint NA   = -LS * LN * LN + 2 * LS * LS * LN - LS * LS * LS;
    localparam longint NC   = LS * LN * LN + 4 * LS * LS * LN - 3 * LS * LS * LS;
    localparam longint NE   = -LS * LS * LN + LS * LS * LS;
    localparam longint VA   = 2 * NA * ONE_Q + DEN;
    localparam longint VC   = 2 * NC * ONE_Q + DEN;
    localparam longint VE   = 2 * NE * ONE_Q + DEN;
    localparam longint W0   = (VA >= 0) ? VA / DEN2 : -((-VA + DEN2 - 1) / DEN2);
    localparam longint W2   = (VC >= 0) ? VC / DEN2 : -((-VC + DEN2 - 1) / DEN2);
    localparam longint W3   = (VE >= 0) ? VE / DEN2 : -((-VE + DEN2 - 1) / DEN2);
    localparam longint W1   = ONE_Q - W0 - W2 - W3;
    assign w_tab[gs] = {WEIGHT_W'(W3), WEIGHT_W'(W2), WEIGHT_W'(W1), WEIGHT_W'(W0)};
  end

  logic [CNT_W-1:0] s_q, s_d;
  logic             en1, en2, en3, en4, issue;

  // Stage 1: weights and points.
  logic                     v1_q;
  logic [3:0][WEIGHT_W-1:0] s1_w_q;
  logic [3:0][COORD_W-1:0]  s1_px_q, s1_py_q;
  logic                     s1_fin_q;
  // Stage 2: products.
  logic                     v2_q;
  logic signed [PROD_W-1:0] s2_px_q [4];
  logic signed [PROD_W-1:0] s2_py_q [4];
  logic                     s2_fin_q;
  // Stage 3: sums.
  logic                     v3_q;
  logic signed [SUM_W-1:0]  s3_sx_q, s3_sy_q;
  logic                     s3_fin_q;
  // Stage 4: output register.
  logic                     v4_q;
  logic [COORD_W-1:0]       x_d, y_d;

  // Each stage moves on when the next one is empty or moving.
  assign en4   = !v4_q || !out_stall_i;
  assign en3   = !v3_q || en4;
  assign en2   = !v2_q || en3;
  assign en1   = !v1_q || en2;
  assign issue = job_valid_i && en1;
  assign job_pop_o = issue && (job_i.single || (s_q == CNT_W'(SAMPLES_PER_SEGMENT - 1)));

  // Sample position within the current job.
  always_comb begin
    s_d = s_q;
    if (job_pop_o) begin
      s_d = '0;
    end else if (issue) begin
      s_d = s_q + 1'b1;
    end
  end

  // Round the Q32 sum to Q16 and saturate to the 32-bit range.
  function automatic logic [COORD_W-1:0] round_sat(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    logic [SUM_W-FRAC_W-1:0] q;
    r = v + SUM_W'(1 << (FRAC_W - 1));
    q = r[SUM_W-1:FRAC_W];
    if (q[SUM_W-FRAC_W-1:COORD_W-1] == '0 || q[SUM_W-FRAC_W-1:COORD_W-1] == '1) begin
      return q[COORD_W-1:0];
    end
    return q[SUM_W-FRAC_W-1] ? {1'b1, {(COORD_W - 1){1'b0}}} :
                               {1'b0, {(COORD_W - 1){1'b1}}};
  endfunction

  assign x_d = round_sat(s3_sx_q);
  assign y_d = round_sat(s3_sy_q);

  // Pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q  <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      s_q <= s_d;
      if (en1) v1_q <= issue;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Pipeline data.
  always_ff @(posedge clk_i) begin
    if (en1 && issue) begin
      s1_w_q   <= w_tab[s_q];
      s1_px_q  <= job_i.px;
      s1_py_q  <= job_i.py;
      s1_fin_q <= job_i.single;
    end
    if (en2 && v1_q) begin
      for (int k = 0; k < 4; k++) begin
        s2_px_q[k] <= $signed(s1_w_q[k]) * $signed(s1_px_q[k]);
        s2_py_q[k] <= $signed(s1_w_q[k]) * $signed(s1_py_q[k]);
      end
      s2_fin_q <= s1_fin_q;
    end
    if (en3 && v2_q) begin
      s3_sx_q  <= SUM_W'(s2_px_q[0]) + SUM_W'(s2_px_q[1]) +
                  SUM_W'(s2_px_q[2]) + SUM_W'(s2_px_q[3]);
      s3_sy_q  <= SUM_W'(s2_py_q[0]) + SUM_W'(s2_py_q[1]) +
                  SUM_W'(s2_py_q[2]) + SUM_W'(s2_py_q[3]);
      s3_fin_q <= s2_fin_q;
    end
    if (en4 && v3_q) begin
      curve_x_o      <= x_d;
      curve_y_o      <= y_d;
      final_sample_o <= s3_fin_q;
    end
  end

  assign out_valid_o = v4_q;

  // The sample counter never runs past the last position of a segment.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_q <= CNT_W'(SAMPLES_PER_SEGMENT - 1))
    else $error("back: sample counter out of range");

  // A single end-point job starts at the identity weights.
  a_single_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && job_i.single) |-> (s_q == '0))
    else $error("back: end point issued in the middle of a segment");

  // A job taken from the queue always starts the next one at position zero.
  a_pop_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (s_q == '0))
    else $error("back: sample counter not cleared after a job");

endmodule
`default_nettype wire

// ----- tb/tb_catmull_rom_curve_sampler_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_catmull_rom_curve_sampler_top
// Self-checking testbench for the Catmull-Rom curve sampler.
// ----------------------------------------------------------------------------
// Runs of Q16.16 control points are sent through the input channel. Each
// accepted point is run through a local model of the spline window, and the
// samples it should cause are queued. Every sample that leaves the block is
// compared with the oldest queued one. A short table of hand-picked runs
// comes first, then random runs of random length. Both channels insert
// random idle and stall cycles, with occasional stretches of full speed.
// ----------------------------------------------------------------------------
module tb_catmull_rom_curve_sampler_top;

  localparam int unsigned N         = 12;
  localparam int unsigned CW        = crs_pkg::COORD_W;
  localparam int unsigned LIMIT     = 600000;
  localparam int unsigned N_RANDOM  = 250;
  localparam int unsigned DRAIN     = 40;
  localparam logic [CW-1:0] CMAX    = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] CMIN    = 32'h8000_0000;

  // One sample on the output channel.
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          fin;
  } sample_t;

  // Four control points in curve order, index 0 first.
  typedef logic [0:3][CW-1:0] quad_t;

  // One row of the directed table. Typed rows carry the expected samples:
  // n copies of (ex, ey), the closing one marked final on a last point.
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          last;
    logic          typed;
    logic [5:0]    n;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
  } row_t;

  localparam int unsigned N_ROWS = 20;
  localparam row_t DIRECTED [N_ROWS] = '{
    // A lone point marked last is a run of one and produces nothing.
    '{32'h0001_0000, 32'hFFFF_0000, 1'b1, 1'b1, 6'd0, 32'h0, 32'h0},
    // Two equal points at the positive limit: one clamped segment, then the end.
    '{CMAX, CMAX, 1'b0, 1'b1, 6'd0, CMAX, CMAX},
    '{CMAX, CMAX, 1'b1, 1'b1, 6'(N + 1), CMAX, CMAX},
    // Four equal points at the negative limit reach the largest emission.
    '{CMIN, CMIN, 1'b0, 1'b1, 6'd0, CMIN, CMIN},
    '{CMIN, CMIN, 1'b0, 1'b1, 6'd0, CMIN, CMIN},
    '{CMIN, CMIN, 1'b0, 1'b1, 6'(N), CMIN, CMIN},
    '{CMIN, CMIN, 1'b1, 1'b1, 6'(2 * N + 1), CMIN, CMIN},
    // Three points at the origin.
    '{32'h0, 32'h0, 1'b0, 1'b1, 6'd0, 32'h0, 32'h0},
    '{32'h0, 32'h0, 1'b0, 1'b1, 6'd0, 32'h0, 32'h0},
    '{32'h0, 32'h0, 1'b1, 1'b1, 6'(2 * N + 1), 32'h0, 32'h0},
    // Two distinct points far apart.
    '{32'h0, 32'h0, 1'b0, 1'b0, 6'd0, 32'h0, 32'h0},
    '{CMAX, CMIN, 1'b1, 1'b0, 6'd0, 32'h0, 32'h0},
    // Alternating extremes overshoot and must saturate.
    '{CMAX, CMIN, 1'b0, 1'b0, 6'd0, 32'h0, 32'h0},
    '{CMIN, CMAX, 1'b0, 1'b0, 6'd0, 32'h0, 32'h0},
    '{CMAX, CMIN, 1'b0, 1'b0, 6'd0, 32'h0, 32'h0},
    '{CMIN, CMAX, 1'b0, 1'b0, 6'd0, 32'h0, 32'h0},
    '{CMAX, CMIN, 1'b1, 1'b0, 6'd0, 32'h0, 32'h0},
    // Tiny steps exercise the rounding of the weights.
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0, 32'h0, 32'h0},
    '{32'h0001_8000, 32'h0000_0003, 1'b0, 1'b0, 6'd0, 32'h0, 32'h0},
    '{32'hFFFE_7FFF, 32'h0000_0002, 1'b1, 1'b0, 6'd0, 32'h0, 32'h0}
  };

  logic          clk = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic [CW-1:0] point_x_i;
  logic [CW-1:0] point_y_i;
  logic          last_point_i;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [CW-1:0] curve_x_o;
  logic [CW-1:0] curve_y_o;
  logic          final_sample_o;

  // Local copy of the spline window and the samples still to come.
  longint        weight_tab [N][4];
  logic [CW-1:0] win_x [3];
  logic [CW-1:0] win_y [3];
  int unsigned   held;
  sample_t       fresh [$];
  sample_t       samples_due [$];

  int unsigned   fail_cnt = 0;
  int unsigned   cycle_cnt = 0;
  int unsigned   rx_hold;
  int unsigned   stall_left = 0;
  bit            calm_in;
  bit            calm_out = 1'b0;

  catmull_rom_curve_sampler_top #(
    .SAMPLES_PER_SEGMENT(N)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .last_point_i  (last_point_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .curve_x_o     (curve_x_o),
    .curve_y_o     (curve_y_o),
    .final_sample_o(final_sample_o)
  );

  // Clock with a period of 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Floor division for a positive divisor.
  function automatic longint floor_div(longint v, longint d);
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  // Division rounded to nearest, ties toward plus infinity.
  function automatic longint near_div(longint v, longint d);
    return floor_div(2 * v + d, 2 * d);
  endfunction

  // One coordinate of sample s, rounded and saturated to 32 bits.
  function automatic logic [CW-1:0] blend(int s, quad_t p);
    longint acc;
    longint r;
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      acc += weight_tab[s][k] * longint'($signed(p[k]));
    end
    r = near_div(acc, 65536);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[CW-1:0];
  endfunction

  // Queue all samples of one segment.
  function automatic void emit_segment(quad_t px, quad_t py);
    for (int s = 0; s < N; s++) begin
      fresh.insert(fresh.size(), '{blend(s, px), blend(s, py), 1'b0});
    end
  endfunction

  // Advance the window model by one point and collect the samples it causes.
  function automatic void plan_point(logic [CW-1:0] qx, logic [CW-1:0] qy, logic last);
    fresh.delete();
    if (held == 0) begin
      if (!last) begin
        win_x = '{win_x[1], win_x[2], qx};
        win_y = '{win_y[1], win_y[2], qy};
        held = 1;
      end
      return;
    end
    if (held == 2) begin
      emit_segment({win_x[1], win_x[1], win_x[2], qx}, {win_y[1], win_y[1], win_y[2], qy});
    end else if (held == 3) begin
      emit_segment({win_x[0], win_x[1], win_x[2], qx}, {win_y[0], win_y[1], win_y[2], qy});
    end
    if (last) begin
      // The closing segment clamps its far neighbour to the end point.
      if (held == 1) begin
        emit_segment({win_x[2], win_x[2], qx, qx}, {win_y[2], win_y[2], qy, qy});
      end else begin
        emit_segment({win_x[1], win_x[2], qx, qx}, {win_y[1], win_y[2], qy, qy});
      end
      fresh.insert(fresh.size(), '{qx, qy, 1'b1});
      held = 0;
    end else begin
      win_x = '{win_x[1], win_x[2], qx};
      win_y = '{win_y[1], win_y[2], qy};
      held = (held < 3) ? held + 1 : 3;
    end
  endfunction

  // Random coordinate: wide, near the previous one, an extreme, or small.
  function automatic logic [CW-1:0] draw_coord(logic [CW-1:0] prev);
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind <= 3) return $urandom;
    if (kind <= 6) return prev + CW'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
    if (kind == 7) begin
      case ($urandom_range(0, 4))
        0: return CMAX;
        1: return CMIN;
        2: return 32'h0;
        3: return 32'h0000_0001;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return CW'($signed($urandom_range(0, 2 ** 19)) - 2 ** 18);
  endfunction

  // Present one point and hold it until the transaction completes.
  task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic last);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i   <= 1'b1;
    point_x_i    <= x;
    point_y_i    <= y;
    last_point_i <= last;
    do @(posedge clk); while (in_stall_o);
  endtask

  // Output checker and random stall of the receiving side.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (samples_due.size() == 0) begin
        $error("unexpected sample x=%h y=%h final=%b", curve_x_o, curve_y_o,
               final_sample_o);
        fail_cnt++;
      end else begin
        if (curve_x_o !== samples_due[0].x) begin
          $error("curve_x: expected %h, got %h", samples_due[0].x, curve_x_o);
          fail_cnt++;
        end
        if (curve_y_o !== samples_due[0].y) begin
          $error("curve_y: expected %h, got %h", samples_due[0].y, curve_y_o);
          fail_cnt++;
        end
        if (final_sample_o !== samples_due[0].fin) begin
          $error("final_sample: expected %b, got %b", samples_due[0].fin, final_sample_o);
          fail_cnt++;
        end
        void'(samples_due.pop_front());
      end
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      rx_hold = calm_out ? 0 : $urandom_range(0, 5);
      stall_left  <= rx_hold;
      out_stall_i <= (rx_hold != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    if (cycle_cnt >= LIMIT) begin
      $display("tb_catmull_rom_curve_sampler_top: errors");
      $finish;
    end
  end

  // Reset, directed table, random runs, drain.
  initial begin : stimulus
    longint        n3;
    longint        s;
    longint        a;
    longint        c;
    longint        e;
    int unsigned   sent;
    int unsigned   run_len;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic          last;

    held         = 0;
    calm_in      = 1'b0;
    win_x        = '{default: '0};
    win_y        = '{default: '0};
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    point_x_i    <= '0;
    point_y_i    <= '0;
    last_point_i <= 1'b0;

    // Basis weights in Q16, the second one taking up the rounding slack.
    n3 = 2 * N * N * N;
    for (int k = 0; k < N; k++) begin
      s = k;
      a = -s * N * N + 2 * s * s * N - s * s * s;
      c = s * N * N + 4 * s * s * N - 3 * s * s * s;
      e = -s * s * N + s * s * s;
      weight_tab[k][0] = near_div(a * 65536, n3);
      weight_tab[k][2] = near_div(c * 65536, n3);
      weight_tab[k][3] = near_div(e * 65536, n3);
      weight_tab[k][1] = 65536 - weight_tab[k][0] - weight_tab[k][2] - weight_tab[k][3];
    end

    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;

    // Hand-picked runs.
    for (int r = 0; r < N_ROWS; r++) begin
      send_point(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].last);
      plan_point(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].last);
      if (DIRECTED[r].typed) begin
        for (int k = 0; k < int'(DIRECTED[r].n); k++) begin
          samples_due.insert(samples_due.size(),
                             '{DIRECTED[r].ex, DIRECTED[r].ey,
                               DIRECTED[r].last && (k == int'(DIRECTED[r].n) - 1)});
        end
      end else begin
        foreach (fresh[k]) samples_due.insert(samples_due.size(), fresh[k]);
      end
    end

    // Random runs; mostly two to eight points, some lone points, a few long.
    sent = 0;
    px   = 32'h0;
    py   = 32'h0;
    while (sent < N_RANDOM) begin
      case ($urandom_range(0, 9))
        0:       run_len = 1;
        1:       run_len = $urandom_range(9, 20);
        default: run_len = $urandom_range(2, 8);
      endcase
      for (int k = 0; k < run_len; k++) begin
        px   = draw_coord(px);
        py   = draw_coord(py);
        last = (k == run_len - 1);
        send_point(px, py, last);
        plan_point(px, py, last);
        foreach (fresh[j]) samples_due.insert(samples_due.size(), fresh[j]);
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    while (samples_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("tb_catmull_rom_curve_sampler_top: clean");
    end else begin
      $display("tb_catmull_rom_curve_sampler_top: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
